### rtl/core/chpr_pkg.sv
package chpr_pkg;

  // field widths
  localparam int unsigned LABEL_W   = 4;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned RANGE_W   = 8;
  localparam int unsigned CNT_W     = 18;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned SEL_W     = 2;

  // histogram geometry and saturation
  localparam int unsigned NUM_BINS   = 256;
  localparam int unsigned BIN_W      = $clog2(NUM_BINS);
  localparam int unsigned IDX_W      = BIN_W + 1;
  localparam int unsigned MAX_PIXELS = 131072;

  // floor(x / 10) as (x * DIV_RECIP) >> DIV_SHIFT, exact for x below 2**22
  localparam int unsigned DIV_RECIP = 838861;
  localparam int unsigned REC_W     = 20;
  localparam int unsigned DIV_SHIFT = 23;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_CLUSTER = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL = 2'd1;

  // channel selector codes
  localparam logic [SEL_W-1:0] CH_HUE = 2'd0;
  localparam logic [SEL_W-1:0] CH_SAT = 2'd1;

  // microprogram step addresses
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] S_IDLE    = 4'd0;
  localparam logic [STEP_W-1:0] S_INC     = 4'd1;
  localparam logic [STEP_W-1:0] S_PK0     = 4'd2;
  localparam logic [STEP_W-1:0] S_PK      = 4'd3;
  localparam logic [STEP_W-1:0] S_THR     = 4'd4;
  localparam logic [STEP_W-1:0] S_DN_RD   = 4'd5;
  localparam logic [STEP_W-1:0] S_DN_CK   = 4'd6;
  localparam logic [STEP_W-1:0] S_UP_RD   = 4'd7;
  localparam logic [STEP_W-1:0] S_UP_CK   = 4'd8;
  localparam logic [STEP_W-1:0] S_OUT     = 4'd9;
  localparam logic [STEP_W-1:0] S_CLR     = 4'd10;

  typedef enum logic [3:0] {
    OP_ACCEPT,
    OP_INC,
    OP_PK_READ,
    OP_PK_SCAN,
    OP_THR,
    OP_DN_READ,
    OP_DN_CHECK,
    OP_UP_READ,
    OP_UP_CHECK,
    OP_EMIT,
    OP_CLEAR
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_NO_XFER,
    C_NOT_LAST,
    C_SCAN_MORE,
    C_IDX_MORE,
    C_LO_ZERO,
    C_HI_TOP,
    C_GE_THR,
    C_OUT_BUSY
  } cond_e;

  // one control word: datapath op, jump condition, jump target, fall-through
  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] jmp;
    logic [STEP_W-1:0] nxt;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic xfer;
    logic last;
    logic scan_more;
    logic idx_more;
    logic lo_zero;
    logic hi_top;
    logic ge_thr;
    logic out_busy;
  } flags_t;

  function automatic ctrl_t useq_rom(logic [STEP_W-1:0] step);
    ctrl_t w;
    unique case (step)
      S_IDLE:  w = '{op: OP_ACCEPT,   cond: C_NO_XFER,   jmp: S_IDLE,  nxt: S_INC};
      S_INC:   w = '{op: OP_INC,      cond: C_NOT_LAST,  jmp: S_IDLE,  nxt: S_PK0};
      S_PK0:   w = '{op: OP_PK_READ,  cond: C_NEVER,     jmp: S_PK0,   nxt: S_PK};
      S_PK:    w = '{op: OP_PK_SCAN,  cond: C_SCAN_MORE, jmp: S_PK,    nxt: S_THR};
      S_THR:   w = '{op: OP_THR,      cond: C_NEVER,     jmp: S_THR,   nxt: S_DN_RD};
      S_DN_RD: w = '{op: OP_DN_READ,  cond: C_LO_ZERO,   jmp: S_UP_RD, nxt: S_DN_CK};
      S_DN_CK: w = '{op: OP_DN_CHECK, cond: C_GE_THR,    jmp: S_DN_RD, nxt: S_UP_RD};
      S_UP_RD: w = '{op: OP_UP_READ,  cond: C_HI_TOP,    jmp: S_OUT,   nxt: S_UP_CK};
      S_UP_CK: w = '{op: OP_UP_CHECK, cond: C_GE_THR,    jmp: S_UP_RD, nxt: S_OUT};
      S_OUT:   w = '{op: OP_EMIT,     cond: C_OUT_BUSY,  jmp: S_OUT,   nxt: S_CLR};
      S_CLR:   w = '{op: OP_CLEAR,    cond: C_IDX_MORE,  jmp: S_CLR,   nxt: S_IDLE};
      default: w = '{op: OP_CLEAR,    cond: C_NEVER,     jmp: S_CLR,   nxt: S_CLR};
    endcase
    return w;
  endfunction

endpackage

### rtl/core/chpr_if.sv
interface chpr_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [chpr_pkg::LABEL_W-1:0]  pixel_label;
  logic [chpr_pkg::CHAN_W-1:0]   hue;
  logic [chpr_pkg::CHAN_W-1:0]   saturation;
  logic [chpr_pkg::CHAN_W-1:0]   brightness;
  logic                          last_pixel;

  modport source (output valid, pixel_label, hue, saturation, brightness, last_pixel,
                  input ready);
  modport sink (input valid, pixel_label, hue, saturation, brightness, last_pixel,
                output ready);
endinterface

interface chpr_result_if;
  logic                          valid;
  logic                          ready;
  logic [chpr_pkg::RANGE_W-1:0]  range_low;
  logic [chpr_pkg::RANGE_W-1:0]  range_high;
  logic [chpr_pkg::CNT_W-1:0]    pixel_count;

  modport source (output valid, range_low, range_high, pixel_count, input ready);
  modport sink (input valid, range_low, range_high, pixel_count, output ready);
endinterface

interface chpr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [chpr_pkg::CFG_ADDR_W-1:0]  addr;
  logic [chpr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

### rtl/core/chpr_bin_ram.sv
module chpr_bin_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned DATA_W = 18
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/chpr_useq.sv
module chpr_useq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  chpr_pkg::flags_t  flags_i,
  output chpr_pkg::ctrl_t   ctrl_o
);

  logic [chpr_pkg::STEP_W-1:0] step_q, step_d;
  chpr_pkg::ctrl_t             ctrl;
  logic                        take;

  assign ctrl = chpr_pkg::useq_rom(step_q);

  always_comb begin
    unique case (ctrl.cond)
      chpr_pkg::C_NEVER:     take = 1'b0;
      chpr_pkg::C_NO_XFER:   take = !flags_i.xfer;
      chpr_pkg::C_NOT_LAST:  take = !flags_i.last;
      chpr_pkg::C_SCAN_MORE: take = flags_i.scan_more;
      chpr_pkg::C_IDX_MORE:  take = flags_i.idx_more;
      chpr_pkg::C_LO_ZERO:   take = flags_i.lo_zero;
      chpr_pkg::C_HI_TOP:    take = flags_i.hi_top;
      chpr_pkg::C_GE_THR:    take = flags_i.ge_thr;
      chpr_pkg::C_OUT_BUSY:  take = flags_i.out_busy;
      default:               take = 1'b0;
    endcase
    step_d = take ? ctrl.jmp : ctrl.nxt;
  end

  // reset enters the clearing loop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= chpr_pkg::S_CLR;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

### rtl/core/cluster_histogram_peak_range_core.sv
// channel   dir  handshake       payload
// pixel_i   in   valid / ready   pixel_label, hue, saturation, brightness, last_pixel
// result_o  out  valid / ready   range_low, range_high, pixel_count
// cfg_i     in   valid / ready   addr (0 cluster_select, 1 channel_select), data
//
// a pixel is transferred with its bin read, then its bin is written back saturating if its
// label matches the selected cluster (one write port on the bin ram sets this)
// after the last pixel the sequencer starts the peak read, scans all NUM_BINS bins, sets the
// threshold, widens the range down then up, emits, and clears every bin before the next pixel
// after reset a clearing pass over all NUM_BINS bins runs before the first pixel
// the result sits in an output register; a stalled sink holds the sequencer
// only when the next result is ready to load; cfg_i is always ready
module cluster_histogram_peak_range_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  chpr_pixel_if.sink    pixel_i,
  chpr_result_if.source result_o,
  chpr_cfg_if.sink      cfg_i
);

  localparam int unsigned BinW = chpr_pkg::BIN_W;
  localparam int unsigned CntW = chpr_pkg::CNT_W;
  localparam int unsigned IdxW = chpr_pkg::IDX_W;
  localparam int unsigned RecW = chpr_pkg::REC_W;

  // sequencer
  chpr_pkg::ctrl_t  ctrl;
  chpr_pkg::flags_t flags;

  // configuration
  logic [chpr_pkg::LABEL_W-1:0] cluster_q;
  logic [chpr_pkg::SEL_W-1:0]   channel_q;

  // captured pixel
  logic            sel_q;
  logic            last_q;
  logic [BinW-1:0] bin_q;

  // scan datapath
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] sel_cnt_q, sel_cnt_d;
  logic [CntW-1:0] peak_q, peak_d;
  logic [BinW-1:0] pbin_q, pbin_d;
  logic [CntW-1:0] thr_q, thr_d;
  logic [BinW-1:0] lo_q, lo_d;
  logic [BinW-1:0] hi_q, hi_d;
  logic [CntW+RecW-1:0] prod;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic [chpr_pkg::RANGE_W-1:0]  out_lo_q, out_hi_q;
  logic [CntW-1:0]               out_cnt_q;
  logic                          out_load;

  // bin ram ports
  logic            ram_we;
  logic [BinW-1:0] ram_waddr, ram_raddr;
  logic [CntW-1:0] ram_wdata, ram_rdata;

  logic            pix_xfer;
  logic [chpr_pkg::CHAN_W-1:0] chan_val;
  logic [BinW-1:0] bin_in;

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] v);
    logic [CntW-1:0] r;
    if (int'(v) >= int'(chpr_pkg::MAX_PIXELS)) begin
      r = CntW'(chpr_pkg::MAX_PIXELS);
    end else begin
      r = v + CntW'(1);
    end
    return r;
  endfunction

  chpr_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  chpr_bin_ram #(
    .DEPTH  (chpr_pkg::NUM_BINS),
    .DATA_W (chpr_pkg::CNT_W)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // configuration writes, indexes beyond the list are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_q <= '0;
      channel_q <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.addr == chpr_pkg::CFG_CLUSTER) begin
        cluster_q <= chpr_pkg::LABEL_W'(cfg_i.data);
      end else if (cfg_i.addr == chpr_pkg::CFG_CHANNEL) begin
        channel_q <= chpr_pkg::SEL_W'(cfg_i.data);
      end
    end
  end

  // pixel side: ready only in the accept step
  assign pixel_i.ready = (ctrl.op == chpr_pkg::OP_ACCEPT);
  assign pix_xfer      = pixel_i.valid && pixel_i.ready;

  // channel pick, unused selector code falls to value
  always_comb begin
    unique case (channel_q)
      chpr_pkg::CH_HUE: chan_val = pixel_i.hue;
      chpr_pkg::CH_SAT: chan_val = pixel_i.saturation;
      default:          chan_val = pixel_i.brightness;
    endcase
    if (int'(chan_val) >= int'(chpr_pkg::NUM_BINS)) begin
      bin_in = BinW'(chpr_pkg::NUM_BINS - 1);
    end else begin
      bin_in = BinW'(chan_val);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_xfer) begin
      sel_q  <= (pixel_i.pixel_label == cluster_q);
      last_q <= pixel_i.last_pixel;
      bin_q  <= bin_in;
    end
  end

  // ram addressing per op
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[BinW-1:0];
    ram_wdata = '0;
    ram_raddr = idx_q[BinW-1:0];
    unique case (ctrl.op)
      chpr_pkg::OP_ACCEPT: ram_raddr = bin_in;
      chpr_pkg::OP_INC: begin
        ram_we    = sel_q;
        ram_waddr = bin_q;
        ram_wdata = sat_inc(ram_rdata);
      end
      chpr_pkg::OP_DN_READ: ram_raddr = lo_q - BinW'(1);
      chpr_pkg::OP_UP_READ: ram_raddr = hi_q + BinW'(1);
      chpr_pkg::OP_CLEAR:   ram_we    = 1'b1;
      default: ;
    endcase
  end

  // threshold = floor(peak / 10) via reciprocal multiply
  assign prod = {{RecW{1'b0}}, peak_q} * (CntW+RecW)'(chpr_pkg::DIV_RECIP);

  // output register loads when empty or being drained
  assign out_load = (ctrl.op == chpr_pkg::OP_EMIT) && !(out_valid_q && !result_o.ready);

  always_comb begin
    idx_d     = idx_q;
    sel_cnt_d = sel_cnt_q;
    peak_d    = peak_q;
    pbin_d    = pbin_q;
    thr_d     = thr_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    unique case (ctrl.op)
      chpr_pkg::OP_ACCEPT: ;
      chpr_pkg::OP_INC: begin
        idx_d = '0;
        if (sel_q) begin
          sel_cnt_d = sat_inc(sel_cnt_q);
        end
      end
      chpr_pkg::OP_PK_READ: begin
        idx_d  = idx_q + IdxW'(1);
        peak_d = '0;
        pbin_d = '0;
      end
      chpr_pkg::OP_PK_SCAN: begin
        // data for bin idx-1 arrives while idx is read
        idx_d = idx_q + IdxW'(1);
        if (ram_rdata > peak_q) begin
          peak_d = ram_rdata;
          pbin_d = BinW'(idx_q - IdxW'(1));
        end
      end
      chpr_pkg::OP_THR: begin
        thr_d = CntW'(prod >> chpr_pkg::DIV_SHIFT);
        lo_d  = pbin_q;
        hi_d  = pbin_q;
      end
      chpr_pkg::OP_DN_READ: ;
      chpr_pkg::OP_DN_CHECK: begin
        if (ram_rdata >= thr_q) begin
          lo_d = lo_q - BinW'(1);
        end
      end
      chpr_pkg::OP_UP_READ: ;
      chpr_pkg::OP_UP_CHECK: begin
        if (ram_rdata >= thr_q) begin
          hi_d = hi_q + BinW'(1);
        end
      end
      chpr_pkg::OP_EMIT: idx_d = '0;
      chpr_pkg::OP_CLEAR: begin
        idx_d     = idx_q + IdxW'(1);
        sel_cnt_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_cnt_q <= sel_cnt_d;
    peak_q    <= peak_d;
    pbin_q    <= pbin_d;
    thr_q     <= thr_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
  end

  // sequencer status
  assign flags.xfer      = pix_xfer;
  assign flags.last      = last_q;
  assign flags.scan_more = (int'(idx_q) != int'(chpr_pkg::NUM_BINS));
  assign flags.idx_more  = (int'(idx_q[BinW-1:0]) != int'(chpr_pkg::NUM_BINS - 1));
  assign flags.lo_zero   = (lo_q == '0);
  assign flags.hi_top    = (int'(hi_q) == int'(chpr_pkg::NUM_BINS - 1));
  assign flags.ge_thr    = (ram_rdata >= thr_q);
  assign flags.out_busy  = out_valid_q && !result_o.ready;

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_lo_q  <= chpr_pkg::RANGE_W'(lo_q);
      out_hi_q  <= chpr_pkg::RANGE_W'(hi_q);
      out_cnt_q <= sel_cnt_q;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.range_low   = out_lo_q;
  assign result_o.range_high  = out_hi_q;
  assign result_o.pixel_count = out_cnt_q;

  // every accepted pixel goes straight to its bin update
  a_xfer_then_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_xfer |=> (ctrl.op == chpr_pkg::OP_INC))
    else $error("accepted pixel not followed by bin update");

  // the emitted range brackets the peak bin
  a_range_brackets_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (lo_q <= pbin_q) && (pbin_q <= hi_q))
    else $error("range does not contain peak bin");

  // no pixel is taken while the histogram is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == chpr_pkg::OP_CLEAR) |-> !pixel_i.ready)
    else $error("pixel ready during clear");

  // selected count never passes saturation
  a_count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (int'(result_o.pixel_count) <= int'(chpr_pkg::MAX_PIXELS)))
    else $error("pixel count above saturation");

endmodule
